// ----- design/mpjs_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the multi-policy job scheduler.
// No dependencies.
package mpjs_pkg;

	localparam logic [1:0] OP_ARRIVE = 2'd0;
	localparam logic [1:0] OP_FINISH = 2'd1;
	localparam logic [1:0] OP_EXPIRE = 2'd2;

	localparam logic [2:0] POL_FCFS  = 3'd0;
	localparam logic [2:0] POL_SJF   = 3'd1;
	localparam logic [2:0] POL_PRIO  = 3'd2;
	localparam logic [2:0] POL_PPRIO = 3'd3;
	localparam logic [2:0] POL_PLRT  = 3'd4;
	localparam logic [2:0] POL_RR    = 3'd5;

	localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;

	// one job record
	typedef struct packed {
		logic [15:0] id;
		logic [31:0] arrival;
		logic [31:0] length;
		logic [31:0] remaining;
		logic [15:0] prio;
		logic [31:0] first_start;
		logic        has_run;
		logic [31:0] order;
	} job_t;

	// candidate travelling down the selection chain
	typedef struct packed {
		logic  found;
		job_t  job;
	} cand_t;

	// true when a ranks before b under policy pol (key, then arrival; never under round robin)
	function automatic logic key_less(input logic [2:0] pol, input job_t a, input job_t b);
		logic lt, eq;
		begin
			unique case (pol)
				POL_SJF: begin
					lt = a.length < b.length;
					eq = a.length == b.length;
				end
				POL_PRIO, POL_PPRIO: begin
					lt = a.prio < b.prio;
					eq = a.prio == b.prio;
				end
				POL_PLRT: begin
					lt = a.remaining > b.remaining;
					eq = a.remaining == b.remaining;
				end
				default: begin
					lt = 1'b0;
					eq = 1'b1;
				end
			endcase
			if (pol == POL_RR)
				key_less = 1'b0;
			else
				key_less = lt || (eq && (a.arrival < b.arrival));
		end
	endfunction

	// equal keys: compare arrival equality too
	function automatic logic key_equal(input logic [2:0] pol, input job_t a, input job_t b);
		logic eq;
		begin
			unique case (pol)
				POL_SJF:             eq = a.length == b.length;
				POL_PRIO, POL_PPRIO: eq = a.prio == b.prio;
				POL_PLRT:            eq = a.remaining == b.remaining;
				default:             eq = 1'b1;
			endcase
			if (pol == POL_RR)
				key_equal = 1'b1;
			else
				key_equal = eq && (a.arrival == b.arrival);
		end
	endfunction

endpackage

// ----- design/mpjs_cell.sv -----
`timescale 1ns / 1ps
// One slot of the waiting table plus one registered step of the best-job chain.
// Depends on mpjs_pkg.
module mpjs_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [2:0]          pol,
	input  logic                wr,
	input  mpjs_pkg::job_t      wr_job,
	input  logic                clr,
	input  mpjs_pkg::cand_t     cand_in,
	output mpjs_pkg::cand_t     cand_out,
	output logic                lead,
	output logic                valid
);
	logic            valid_q;
	mpjs_pkg::job_t  job_q;
	mpjs_pkg::cand_t cand_q, cand_d;
	logic            lead_q;
	logic            better, take;

	// slot storage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (wr)
			valid_q <= 1'b1;
		else if (clr)
			valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (wr)
			job_q <= wr_job;
	end

	// compare own entry against the best so far
	always_comb begin
		better = mpjs_pkg::key_less(pol, job_q, cand_in.job) ||
			(mpjs_pkg::key_equal(pol, job_q, cand_in.job) &&
			 ((job_q.order - cand_in.job.order) >> 31) == 32'd1);
		take = valid_q && (!cand_in.found || better);
		cand_d = cand_in;
		if (take) begin
			cand_d.found = 1'b1;
			cand_d.job   = job_q;
		end
	end

	// hand the best so far to the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cand_q <= '0;
			lead_q <= 1'b0;
		end else begin
			cand_q <= cand_d;
			lead_q <= take;
		end
	end

	assign cand_out = cand_q;
	assign lead     = lead_q;
	assign valid    = valid_q;
endmodule

// ----- design/multi_policy_job_scheduler.sv -----
`timescale 1ns / 1ps
// Top level: single-core job scheduler over a chain of table slots.
// Depends on mpjs_pkg and mpjs_cell.
// Each event runs through the states in order: charge and insert (ST_EXEC), let the
// selection cross the registered slot chain (ST_WALK), dispatch and add the totals
// (ST_PICK), then hold the result (ST_DONE). One item at a time: the next item is
// taken only after the result of the previous one has been accepted.
// Reset clears the core, the totals and all slot valid bits at once.
module multi_policy_job_scheduler #(
	parameter int MAX_JOBS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_wdata,
	input  logic         s_tvalid,
	output logic         s_tready,
	// op[1:0]
	input  logic [1:0]   s_tuser,
	// job_id[15:0], event_time[47:16], run_length[79:48], job_priority[95:80]
	input  logic [95:0]  s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// running_valid[0], running_id[16:1], started_now[17], dropped[18],
	// served_count[50:19], total_waiting[98:51], total_response[146:99],
	// total_turnaround[194:147]
	output logic [199:0] m_tdata
);
	localparam int IW = $clog2(MAX_JOBS);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_EXEC = 5'b00010,
		ST_WALK = 5'b00100,
		ST_PICK = 5'b01000,
		ST_DONE = 5'b10000
	} state_t;

	state_t st_q;
	logic [2:0]  pol_q;
	logic [1:0]  op_q;
	logic [15:0] id_q, pr_q;
	logic [31:0] t_q, len_q;
	logic        busy_q, started_q, dropped_q, need_pick_q;
	mpjs_pkg::job_t core_q;
	logic [31:0] charge_q, seq_q, served_q;
	logic [47:0] sw_q, sr_q, st2_q;
	logic [47:0] dw_q, dr_q, dt_q;
	logic        add_q;
	logic [IW-1:0] cnt_q;

	// chain
	logic [MAX_JOBS-1:0] vld, wr_v, clr_v, lead_v;
	mpjs_pkg::cand_t chain [MAX_JOBS+1];
	mpjs_pkg::job_t  wr_job;
	logic [IW-1:0]   free_idx, best_idx;
	logic            free_ok;

	// per-event helpers
	mpjs_pkg::job_t nj, nj_run, core_c, pick_job;
	logic [31:0] el, rem_c;
	logic        preempt;

	assign chain[0] = '0;
	genvar g;
	generate
		for (g = 0; g < MAX_JOBS; g++) begin : g_cell
			mpjs_cell u_cell (
				.clk(clk), .arst_n(arst_n), .pol(pol_q),
				.wr(wr_v[g]), .wr_job(wr_job), .clr(clr_v[g]),
				.cand_in(chain[g]), .cand_out(chain[g+1]), .lead(lead_v[g]),
				.valid(vld[g])
			);
		end
	endgenerate

	// first free slot, and the slot that last took the lead
	always_comb begin
		free_ok  = 1'b0;
		free_idx = '0;
		for (int i = MAX_JOBS - 1; i >= 0; i--)
			if (!vld[i]) begin
				free_ok  = 1'b1;
				free_idx = IW'(i);
			end
		best_idx = '0;
		for (int i = 0; i < MAX_JOBS; i++)
			if (lead_v[i])
				best_idx = IW'(i);
	end

	// new job from the input item, charged core job, dispatched job
	always_comb begin
		nj.id = id_q; nj.arrival = t_q; nj.length = len_q; nj.remaining = len_q;
		nj.prio = pr_q; nj.first_start = t_q; nj.has_run = 1'b0; nj.order = '0;
		nj_run = nj;
		nj_run.has_run = 1'b1;
		el = (t_q >= charge_q) ? t_q - charge_q : 32'd0;
		rem_c = (core_q.remaining > el) ? core_q.remaining - el : 32'd0;
		core_c = core_q;
		core_c.remaining = rem_c;
		preempt = (pol_q == mpjs_pkg::POL_PPRIO || pol_q == mpjs_pkg::POL_PLRT) &&
			mpjs_pkg::key_less(pol_q, nj, core_c);
		pick_job = chain[MAX_JOBS].job;
		if (!pick_job.has_run)
			pick_job.first_start = t_q;
		pick_job.has_run = 1'b1;
	end

	// slot write controls
	always_comb begin
		wr_v   = '0;
		clr_v  = '0;
		wr_job = core_c;
		wr_job.order = seq_q;
		if (st_q == ST_EXEC && busy_q && free_ok) begin
			if (op_q == mpjs_pkg::OP_EXPIRE ||
				(op_q == mpjs_pkg::OP_ARRIVE && preempt))
				wr_v[free_idx] = 1'b1;
			else if (op_q == mpjs_pkg::OP_ARRIVE) begin
				wr_v[free_idx] = 1'b1;
				wr_job = nj;
				wr_job.order = seq_q;
			end
		end
		if (st_q == ST_PICK && need_pick_q && chain[MAX_JOBS].found)
			clr_v[best_idx] = 1'b1;
	end

	function automatic logic [47:0] sat(input logic [47:0] s, input logic [47:0] d);
		sat = (d >= mpjs_pkg::MAX48 - s) ? mpjs_pkg::MAX48 : s + d;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE; pol_q <= '0; busy_q <= 1'b0; core_q <= '0;
			charge_q <= '0; seq_q <= '0; served_q <= '0;
			sw_q <= '0; sr_q <= '0; st2_q <= '0; add_q <= 1'b0;
			started_q <= 1'b0; dropped_q <= 1'b0; need_pick_q <= 1'b0;
			op_q <= '0; id_q <= '0; pr_q <= '0; t_q <= '0; len_q <= '0;
			dw_q <= '0; dr_q <= '0; dt_q <= '0; cnt_q <= '0;
		end else begin
			if (cfg_we)
				pol_q <= cfg_wdata;
			unique case (st_q)
				ST_IDLE: if (s_tvalid) begin
					op_q  <= s_tuser;
					id_q  <= s_tdata[15:0];
					t_q   <= s_tdata[47:16];
					len_q <= s_tdata[79:48];
					pr_q  <= s_tdata[95:80];
					st_q  <= ST_EXEC;
				end
				ST_EXEC: begin
					// event flags
					started_q <= (op_q == mpjs_pkg::OP_ARRIVE) &&
						(!busy_q || (free_ok && preempt));
					dropped_q <= (op_q == mpjs_pkg::OP_ARRIVE) && busy_q && !free_ok;
					need_pick_q <= busy_q && ((op_q == mpjs_pkg::OP_FINISH) ||
						(op_q == mpjs_pkg::OP_EXPIRE && free_ok));
					add_q <= busy_q && (op_q == mpjs_pkg::OP_FINISH) &&
						(core_q.id == id_q);
					// time terms of a finishing job
					dw_q <= ({16'd0, t_q} > {16'd0, core_q.arrival} +
						{16'd0, core_q.length}) ? {16'd0, t_q} -
						{16'd0, core_q.arrival} - {16'd0, core_q.length} : '0;
					dr_q <= (core_q.first_start > core_q.arrival) ?
						{16'd0, core_q.first_start - core_q.arrival} : '0;
					dt_q <= (t_q > core_q.arrival) ?
						{16'd0, t_q - core_q.arrival} : '0;
					if (busy_q && free_ok && (op_q == mpjs_pkg::OP_ARRIVE ||
						op_q == mpjs_pkg::OP_EXPIRE))
						seq_q <= seq_q + 32'd1;
					unique case (op_q)
						mpjs_pkg::OP_ARRIVE: begin
							charge_q <= t_q;
							if (!busy_q) begin
								core_q <= nj_run; busy_q <= 1'b1;
							end else begin
								core_q <= (free_ok && preempt) ? nj_run : core_c;
							end
						end
						mpjs_pkg::OP_FINISH: if (busy_q) begin
							if (served_q != 32'hFFFF_FFFF)
								served_q <= served_q + 32'd1;
						end
						mpjs_pkg::OP_EXPIRE: if (busy_q) begin
							core_q <= core_c; charge_q <= t_q;
						end
						default: ;
					endcase
					cnt_q <= IW'(MAX_JOBS - 1);
					st_q <= ST_WALK;
				end
				// let the selection settle through every cell
				ST_WALK: begin
					if (cnt_q == '0)
						st_q <= ST_PICK;
					else
						cnt_q <= cnt_q - 1'b1;
				end
				ST_PICK: begin
					if (add_q) begin
						sw_q <= sat(sw_q, dw_q);
						sr_q <= sat(sr_q, dr_q);
						st2_q <= sat(st2_q, dt_q);
					end
					if (need_pick_q) begin
						if (chain[MAX_JOBS].found) begin
							core_q <= pick_job;
							charge_q <= t_q; busy_q <= 1'b1;
						end else begin
							core_q <= '0; busy_q <= 1'b0;
						end
					end
					st_q <= ST_DONE;
				end
				ST_DONE: if (m_tready)
					st_q <= ST_IDLE;
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	assign s_tready = (st_q == ST_IDLE);
	assign m_tvalid = (st_q == ST_DONE);
	assign m_tdata = {5'd0, st2_q, sr_q, sw_q, served_q, dropped_q, started_q,
		busy_q ? core_q.id : 16'd0, busy_q};
endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for multi_policy_job_scheduler: directed table, then random events.
// Depends on mpjs_pkg and the scheduler RTL; its own scheduling model predicts every result but typed-in ones.
module tb;

	localparam int SLOTS = 16;
	localparam longint CYCLE_LIMIT = 2000000;
	localparam logic [1:0] OP_NONE = 2'd3;

	typedef struct {
		logic [15:0] id;
		logic [31:0] arrival;
		logic [31:0] length;
		logic [31:0] remaining;
		logic [15:0] prio;
		logic [31:0] first_start;
		logic        has_run;
		logic [31:0] order;
	} job_rec;

	typedef struct {
		logic [1:0]  op;
		logic [15:0] id;
		logic [31:0] t;
		logic [31:0] len;
		logic [15:0] prio;
	} sched_event;

	typedef struct packed {
		logic        run_valid;
		logic [15:0] run_id;
		logic        started;
		logic        dropped;
		logic [31:0] served;
		logic [47:0] waiting;
		logic [47:0] response;
		logic [47:0] turnaround;
	} sched_status;

	// one directed row: event, and a typed-in expectation where fixed is set
	typedef struct {
		sched_event  ev;
		bit          fixed;
		sched_status exp;
	} dir_row;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_wdata = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [1:0] s_tuser = '0;
	logic [95:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [199:0] m_tdata;

	multi_policy_job_scheduler dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always #5 clk = ~clk;

	// scheduler shadow state
	logic [2:0]  sh_policy;
	logic        sh_valid [SLOTS];
	job_rec      sh_table [SLOTS];
	logic [31:0] sh_seq;
	logic        sh_busy;
	job_rec      sh_core;
	logic [31:0] sh_charge;
	logic [31:0] sh_served;
	logic [47:0] sh_wait, sh_resp, sh_turn;

	sched_status status_q[$];
	dir_row dir_tab[$];
	int mismatches = 0;
	longint cycles = 0;
	bit tx_done = 0;

	function automatic int cmp32(logic [31:0] a, logic [31:0] b);
		return a < b ? -1 : (a > b ? 1 : 0);
	endfunction

	// ordering under current policy: negative when a ranks first
	function automatic int rank_cmp(job_rec a, job_rec b);
		int c;
		c = 0;
		case (sh_policy)
			mpjs_pkg::POL_SJF: c = cmp32(a.length, b.length);
			mpjs_pkg::POL_PRIO, mpjs_pkg::POL_PPRIO:
				c = cmp32({16'd0, a.prio}, {16'd0, b.prio});
			mpjs_pkg::POL_PLRT: c = cmp32(b.remaining, a.remaining);
			mpjs_pkg::POL_RR: return 0;
			default: c = 0;
		endcase
		if (c != 0) return c;
		return cmp32(a.arrival, b.arrival);
	endfunction

	function automatic int open_slot();
		for (int i = 0; i < SLOTS; i++)
			if (!sh_valid[i]) return i;
		return -1;
	endfunction

	function automatic void park(int i, job_rec j);
		sh_table[i] = j;
		sh_table[i].order = sh_seq;
		sh_seq++;
		sh_valid[i] = 1'b1;
	endfunction

	function automatic void bill_core(logic [31:0] t);
		logic [31:0] el;
		el = t >= sh_charge ? t - sh_charge : 32'd0;
		sh_core.remaining = sh_core.remaining > el ? sh_core.remaining - el : 32'd0;
		sh_charge = t;
	endfunction

	function automatic void pick_next(logic [31:0] t);
		int best, c;
		logic [31:0] d;
		best = -1;
		for (int i = 0; i < SLOTS; i++) begin
			if (!sh_valid[i]) continue;
			if (best < 0) begin
				best = i;
				continue;
			end
			c = rank_cmp(sh_table[i], sh_table[best]);
			d = sh_table[i].order - sh_table[best].order;
			if (c < 0 || (c == 0 && d[31])) best = i;
		end
		if (best < 0) begin
			sh_busy = 1'b0;
			sh_core = '{default: '0};
			return;
		end
		sh_valid[best] = 1'b0;
		sh_core = sh_table[best];
		if (!sh_core.has_run) sh_core.first_start = t;
		sh_core.has_run = 1'b1;
		sh_charge = t;
		sh_busy = 1'b1;
	endfunction

	function automatic logic [47:0] add_sat(logic [47:0] s, logic [63:0] d);
		return (d >= {16'd0, mpjs_pkg::MAX48 - s}) ? mpjs_pkg::MAX48 : s + d[47:0];
	endfunction

	function automatic void scheduler_reset();
		sh_policy = mpjs_pkg::POL_FCFS;
		foreach (sh_valid[i]) sh_valid[i] = 1'b0;
		sh_seq = 0; sh_busy = 0; sh_core = '{default: '0}; sh_charge = 0;
		sh_served = 0; sh_wait = 0; sh_resp = 0; sh_turn = 0;
	endfunction

	function automatic sched_status schedule(sched_event e);
		sched_status r;
		job_rec nj;
		int s;
		logic [63:0] fin, a, al;
		r = '0;
		case (e.op)
			mpjs_pkg::OP_ARRIVE: begin
				nj = '{id: e.id, arrival: e.t, length: e.len, remaining: e.len,
					prio: e.prio, first_start: e.t, has_run: 1'b0, order: 32'd0};
				if (!sh_busy) begin
					sh_core = nj; sh_core.has_run = 1; sh_charge = e.t;
					sh_busy = 1; r.started = 1;
				end else begin
					bill_core(e.t);
					s = open_slot();
					if (s < 0) r.dropped = 1;
					else if ((sh_policy == mpjs_pkg::POL_PPRIO ||
							sh_policy == mpjs_pkg::POL_PLRT) &&
							rank_cmp(nj, sh_core) < 0) begin
						park(s, sh_core);
						sh_core = nj; sh_core.has_run = 1; sh_charge = e.t;
						r.started = 1;
					end else park(s, nj);
				end
			end
			mpjs_pkg::OP_FINISH: begin
				if (sh_busy) begin
					if (sh_core.id == e.id) begin
						fin = 64'(e.t); a = 64'(sh_core.arrival);
						al = a + 64'(sh_core.length);
						sh_wait = add_sat(sh_wait, fin > al ? fin - al : 64'd0);
						sh_resp = add_sat(sh_resp, sh_core.first_start > sh_core.arrival ?
							64'(sh_core.first_start - sh_core.arrival) : 64'd0);
						sh_turn = add_sat(sh_turn, fin > a ? fin - a : 64'd0);
					end
					if (sh_served != 32'hFFFF_FFFF) sh_served++;
					pick_next(e.t);
				end
			end
			mpjs_pkg::OP_EXPIRE: begin
				if (sh_busy) begin
					bill_core(e.t);
					s = open_slot();
					if (s >= 0) begin
						park(s, sh_core);
						pick_next(e.t);
					end
				end
			end
			default: ;
		endcase
		r.run_valid = sh_busy;
		r.run_id = sh_busy ? sh_core.id : 16'd0;
		r.served = sh_served;
		r.waiting = sh_wait;
		r.response = sh_resp;
		r.turnaround = sh_turn;
		return r;
	endfunction

	function automatic int rand_gap();
		int p;
		p = $urandom_range(0, 99);
		if (p < 50) return 0;
		if (p < 92) return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 5))
			0: return 32'd0;
			1: return 32'hFFFF_FFFF;
			2: return $urandom;
			default: return $urandom_range(0, 200);
		endcase
	endfunction

	// cycle counter and timeout
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("multi_policy_job_scheduler regression: fail");
			$finish;
		end
	end

	// result checker
	always @(posedge clk) begin
		sched_status got, want;
		if (m_tvalid && m_tready) begin
			got.run_valid = m_tdata[0];
			got.run_id = m_tdata[16:1];
			got.started = m_tdata[17];
			got.dropped = m_tdata[18];
			got.served = m_tdata[50:19];
			got.waiting = m_tdata[98:51];
			got.response = m_tdata[146:99];
			got.turnaround = m_tdata[194:147];
			if (status_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %p", got);
			end else begin
				want = status_q.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10) $display("mismatch: exp %p got %p", want, got);
				end
			end
		end
	end

	// result side back-pressure
	initial begin
		int g;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (tx_done && cycles % 2000 < 1000) m_tready <= 1'b1;
			else begin
				g = rand_gap();
				if ($urandom_range(0, 3) == 0 || cycles % 4000 < 800) g = 0;
				m_tready <= (g == 0);
				repeat (g > 0 ? g - 1 : 0) @(negedge clk);
			end
		end
	end

	task automatic send(sched_event e, bit fixed = 1'b0, sched_status exp = '0);
		int g;
		sched_status p;
		g = rand_gap();
		if (g > 0) begin
			s_tvalid <= 1'b0;
			repeat (g) @(negedge clk);
		end
		s_tuser <= e.op;
		s_tdata <= {e.prio, e.len, e.t, e.id};
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		p = schedule(e);
		if (fixed) p = exp;
		status_q.push_back(p);
		@(negedge clk);
	endtask

	task automatic set_policy(logic [2:0] pol);
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (status_q.size() != 0) @(negedge clk);
		repeat (6) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= pol;
		@(negedge clk);
		cfg_we <= 1'b0;
		sh_policy = pol;
	endtask

	function automatic sched_event mk(logic [1:0] op, logic [15:0] id, logic [31:0] t,
			logic [31:0] len, logic [15:0] pr);
		return '{op: op, id: id, t: t, len: len, prio: pr};
	endfunction

	function automatic dir_row row(sched_event e, bit fixed, sched_status exp);
		return '{ev: e, fixed: fixed, exp: exp};
	endfunction

	// directed table: idle finish/expire/unused op, extremes, a full table, a dropped arrival, then expire and finishes
	function automatic void build_table();
		sched_status z, first, drop;
		z = '0;
		first = z;
		first.run_valid = 1'b1;
		first.run_id = 16'hFFFF;
		first.started = 1'b1;
		drop = z;
		drop.run_valid = 1'b1;
		drop.run_id = 16'hFFFF;
		drop.dropped = 1'b1;
		dir_tab.push_back(row(mk(mpjs_pkg::OP_FINISH, 16'h0001, 32'd5, 0, 0), 1'b1, z));
		dir_tab.push_back(row(mk(mpjs_pkg::OP_EXPIRE, 16'h0000, 32'd6, 0, 0), 1'b1, z));
		dir_tab.push_back(row(mk(OP_NONE, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			16'hFFFF), 1'b1, z));
		dir_tab.push_back(row(mk(mpjs_pkg::OP_ARRIVE, 16'hFFFF, 32'd0, 32'hFFFF_FFFF,
			16'hFFFF), 1'b1, first));
		for (int i = 0; i < SLOTS; i++)
			dir_tab.push_back(row(mk(mpjs_pkg::OP_ARRIVE, 16'(i), 32'(i), 32'(20 - i),
				16'(i % 3)), 1'b0, z));
		dir_tab.push_back(row(mk(mpjs_pkg::OP_ARRIVE, 16'(SLOTS), 32'(SLOTS), 32'd4,
			16'd1), 1'b1, drop));
		dir_tab.push_back(row(mk(mpjs_pkg::OP_EXPIRE, 16'd0, 32'hFFFF_FFFF, 0, 0), 1'b0, z));
		dir_tab.push_back(row(mk(mpjs_pkg::OP_FINISH, 16'hFFFF, 32'hFFFF_FFFF, 0, 0),
			1'b0, z));
		dir_tab.push_back(row(mk(mpjs_pkg::OP_FINISH, 16'h1234, 32'd0, 0, 0), 1'b0, z));
	endfunction

	// one burst: arrivals, expiries, finishes of the running job and of random ids, and random malformed events
	task automatic burst(inout logic [31:0] now, input int n);
		sched_event e;
		for (int k = 0; k < n; k++) begin
			now += $urandom_range(0, 20);
			case ($urandom_range(0, 9))
				0, 1, 2, 3: e = mk(mpjs_pkg::OP_ARRIVE, 16'($urandom), now,
					$urandom_range(0, 50), 16'($urandom_range(0, 7)));
				4, 5: e = mk(mpjs_pkg::OP_EXPIRE, 16'($urandom), now, 0, 0);
				6, 7: e = mk(mpjs_pkg::OP_FINISH, sh_core.id, now, 0, 0);
				8: e = mk(2'($urandom_range(0, 3)), 16'($urandom), rand_word(),
					rand_word(), 16'($urandom));
				default: e = mk(mpjs_pkg::OP_FINISH, 16'($urandom),
					now - $urandom_range(0, 30), 0, 0);
			endcase
			if ($urandom_range(0, 30) == 0)
				e = mk(mpjs_pkg::OP_ARRIVE, 16'($urandom), rand_word(), rand_word(),
					16'($urandom));
			send(e);
		end
	endtask

	// directed rows first, then random bursts under each policy
	initial begin
		logic [31:0] now;
		scheduler_reset();
		build_table();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (dir_tab[i])
			send(dir_tab[i].ev, dir_tab[i].fixed, dir_tab[i].exp);

		// policies in turn, extremes included, with bursts of random events
		now = 32'd100;
		for (int r = 0; r < 14; r++) begin
			set_policy(r < 8 ? 3'(r) : 3'($urandom_range(0, 7)));
			burst(now, 140);
		end
		for (int k = 0; k < 20; k++)
			send(mk(mpjs_pkg::OP_FINISH, sh_core.id, 32'hFFFF_FFFF, 0, 0));

		s_tvalid <= 1'b0;
		tx_done = 1;
		while (status_q.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		if (mismatches == 0 && status_q.size() == 0)
			$display("multi_policy_job_scheduler regression: pass");
		else
			$display("multi_policy_job_scheduler regression: fail");
		$finish;
	end

endmodule
